@@ rtl/pgbx_pkg.sv @@
// ----------------------------------------------------------------------------
// pgbx_pkg
// shared constants and types of the polygon edge versus box test
// ----------------------------------------------------------------------------
package pgbx_pkg;

  localparam int DEF_COORD_WIDTH = 32;
  localparam int QUEUE_DEPTH     = 4;

  // register indexes of the configuration port
  localparam int REG_BOX_X_LO  = 0;
  localparam int REG_BOX_X_HI  = 1;
  localparam int REG_BOX_Y_LO  = 2;
  localparam int REG_BOX_Y_HI  = 3;
  localparam int REG_CLOSE     = 4;
  localparam int NUM_REGS      = 5;
  localparam int REG_IDX_W     = 3;

  // per-vertex job flags handed from front to back
  typedef struct packed {
    logic edge_a;   // edge previous -> current is tested
    logic edge_b;   // closing edge current -> ring first is tested
    logic poly_end; // result is due after this vertex
  } pgbx_flags_t;

  localparam int FLAGS_W = $bits(pgbx_flags_t);

endpackage

@@ rtl/pgbx_if.sv @@
// ----------------------------------------------------------------------------
// pgbx_if
// valid/ready channels for vertices and results
// ----------------------------------------------------------------------------
interface pgbx_vertex_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          ring_last;
  logic                          poly_last;

  modport source (output valid, vertex_x, vertex_y, ring_last, poly_last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, ring_last, poly_last, output ready);
endinterface

interface pgbx_result_if;
  logic valid;
  logic ready;
  logic crosses;

  modport source (output valid, crosses, input ready);
  modport sink   (input valid, crosses, output ready);
endinterface

@@ rtl/pgbx_queue.sv @@
// ----------------------------------------------------------------------------
// pgbx_queue
// small fifo between the front and back parts
// ----------------------------------------------------------------------------
module pgbx_queue
  import pgbx_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

@@ rtl/pgbx_front.sv @@
// ----------------------------------------------------------------------------
// pgbx_front
// takes vertices, tracks ring state and forms one edge job per vertex
// ----------------------------------------------------------------------------
module pgbx_front
  import pgbx_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      close_ring,
  pgbx_vertex_if.sink               vertex,
  input  logic                      q_full,
  output logic                      q_push,
  output logic [6*COORD_WIDTH+FLAGS_W-1:0] q_data
);
  logic [COORD_WIDTH-1:0] ring_first_x;
  logic [COORD_WIDTH-1:0] ring_first_y;
  logic [COORD_WIDTH-1:0] prev_x;
  logic [COORD_WIDTH-1:0] prev_y;
  logic                   have_prev;
  logic [COORD_WIDTH-1:0] first_x;
  logic [COORD_WIDTH-1:0] first_y;
  logic                   ring_end;
  pgbx_flags_t            flags;

  assign vertex.ready = !q_full;
  assign q_push       = vertex.valid && !q_full;
  assign ring_end     = vertex.ring_last || vertex.poly_last;
  assign first_x      = have_prev ? ring_first_x : vertex.vertex_x;
  assign first_y      = have_prev ? ring_first_y : vertex.vertex_y;

  always_comb begin
    flags.edge_a   = have_prev;
    flags.edge_b   = ring_end && close_ring;
    flags.poly_end = vertex.poly_last;
  end

  assign q_data = {flags, prev_x, prev_y, vertex.vertex_x, vertex.vertex_y,
                   first_x, first_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev    <= 1'b0;
      ring_first_x <= '0;
      ring_first_y <= '0;
      prev_x       <= '0;
      prev_y       <= '0;
    end else if (q_push) begin
      ring_first_x <= first_x;
      ring_first_y <= first_y;
      prev_x       <= vertex.vertex_x;
      prev_y       <= vertex.vertex_y;
      have_prev    <= !ring_end;
    end
  end
endmodule

@@ rtl/pgbx_edge.sv @@
// ----------------------------------------------------------------------------
// pgbx_edge
// three-stage exact segment versus box test
// ----------------------------------------------------------------------------
module pgbx_edge
  import pgbx_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] sx,
  input  logic signed [COORD_WIDTH-1:0] sy,
  input  logic signed [COORD_WIDTH-1:0] ex,
  input  logic signed [COORD_WIDTH-1:0] ey,
  input  logic signed [COORD_WIDTH-1:0] xl,
  input  logic signed [COORD_WIDTH-1:0] xh,
  input  logic signed [COORD_WIDTH-1:0] yl,
  input  logic signed [COORD_WIDTH-1:0] yh,
  output logic                          hit
);
  localparam int D = COORD_WIDTH + 1;
  localparam int P = 2 * D;

  // side order: bottom, top, left, right
  logic signed [COORD_WIDTH-1:0] lvl [4];
  logic signed [COORD_WIDTH-1:0] s0  [4];
  logic signed [COORD_WIDTH-1:0] s1  [4];
  logic signed [COORD_WIDTH-1:0] o0  [4];
  logic signed [COORD_WIDTH-1:0] o1  [4];
  logic signed [COORD_WIDTH-1:0] slo [4];
  logic signed [COORD_WIDTH-1:0] shi [4];

  logic signed [D-1:0] n1   [4];
  logic signed [D-1:0] den1 [4];
  logic signed [D-1:0] num1 [4];
  logic signed [D-1:0] dlo1 [4];
  logic signed [D-1:0] dhi1 [4];
  logic                pre1;
  logic                in1;

  logic signed [P-1:0] lhs2 [4];
  logic signed [P-1:0] plo2 [4];
  logic signed [P-1:0] phi2 [4];
  logic                ok2  [4];
  logic                pre2;
  logic                in2;

  logic [3:0]          side3;
  logic                overlap;
  logic                in_box;

  assign lvl[0] = yl; assign s0[0] = sy; assign s1[0] = ey; assign o0[0] = sx;
  assign o1[0]  = ex; assign slo[0] = xl; assign shi[0] = xh;
  assign lvl[1] = yh; assign s0[1] = sy; assign s1[1] = ey; assign o0[1] = sx;
  assign o1[1]  = ex; assign slo[1] = xl; assign shi[1] = xh;
  assign lvl[2] = xl; assign s0[2] = sx; assign s1[2] = ex; assign o0[2] = sy;
  assign o1[2]  = ey; assign slo[2] = yl; assign shi[2] = yh;
  assign lvl[3] = xh; assign s0[3] = sx; assign s1[3] = ex; assign o0[3] = sy;
  assign o1[3]  = ey; assign slo[3] = yl; assign shi[3] = yh;

  // overlap of sorted ranges and either end point inside box
  always_comb begin
    overlap = ((sx <= ex ? sx : ex) <= (xl <= xh ? xh : xl)) &&
              ((xl <= xh ? xl : xh) <= (sx <= ex ? ex : sx)) &&
              ((sy <= ey ? sy : ey) <= (yl <= yh ? yh : yl)) &&
              ((yl <= yh ? yl : yh) <= (sy <= ey ? ey : sy));
    in_box  = (xl <= ex && ex <= xh && yl <= ey && ey <= yh) ||
              (xl <= sx && sx <= xh && yl <= sy && sy <= yh);
  end

  genvar k;
  generate
    for (k = 0; k < 4; k++) begin : g_side
      logic neg;
      assign neg = s1[k] < s0[k];

      // stage 1: direction and level offset, sign normalized, plus other-axis delta and span offsets
      always_ff @(posedge clk) begin
        if (en) begin
          den1[k] <= neg ? ({s0[k][COORD_WIDTH-1], s0[k]} - {s1[k][COORD_WIDTH-1], s1[k]})
                         : ({s1[k][COORD_WIDTH-1], s1[k]} - {s0[k][COORD_WIDTH-1], s0[k]});
          n1[k]   <= neg ? ({s0[k][COORD_WIDTH-1], s0[k]} - {lvl[k][COORD_WIDTH-1], lvl[k]})
                         : ({lvl[k][COORD_WIDTH-1], lvl[k]} - {s0[k][COORD_WIDTH-1], s0[k]});
          num1[k] <= {o1[k][COORD_WIDTH-1], o1[k]} - {o0[k][COORD_WIDTH-1], o0[k]};
          dlo1[k] <= {slo[k][COORD_WIDTH-1], slo[k]} - {o0[k][COORD_WIDTH-1], o0[k]};
          dhi1[k] <= {shi[k][COORD_WIDTH-1], shi[k]} - {o0[k][COORD_WIDTH-1], o0[k]};
        end
      end

      // stage 2: cross products, t in [0,1]
      always_ff @(posedge clk) begin
        if (en) begin
          lhs2[k] <= num1[k] * n1[k];
          plo2[k] <= dlo1[k] * den1[k];
          phi2[k] <= dhi1[k] * den1[k];
          ok2[k]  <= (den1[k] != '0) && !n1[k][D-1] && (n1[k] <= den1[k]);
        end
      end

      // stage 3: span check
      always_ff @(posedge clk) begin
        if (en) begin
          side3[k] <= ok2[k] && (plo2[k] <= lhs2[k]) && (lhs2[k] <= phi2[k]);
        end
      end
    end
  endgenerate

  logic pre3;
  logic in3;

  always_ff @(posedge clk) begin
    if (en) begin
      pre1 <= overlap;
      in1  <= in_box;
      pre2 <= pre1;
      in2  <= in1;
      pre3 <= pre2;
      in3  <= in2;
    end
  end

  assign hit = pre3 && (in3 || (side3 != 4'b0000));
endmodule

@@ rtl/pgbx_back.sv @@
// ----------------------------------------------------------------------------
// pgbx_back
// runs both edge tests of each job and gathers the polygon result
// ----------------------------------------------------------------------------
module pgbx_back
  import pgbx_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [COORD_WIDTH-1:0]         box_x_lo,
  input  logic signed [COORD_WIDTH-1:0]         box_x_hi,
  input  logic signed [COORD_WIDTH-1:0]         box_y_lo,
  input  logic signed [COORD_WIDTH-1:0]         box_y_hi,
  input  logic                                  q_valid,
  input  logic [6*COORD_WIDTH+FLAGS_W-1:0]      q_data,
  output logic                                  q_pop,
  pgbx_result_if.source                         result
);
  logic signed [COORD_WIDTH-1:0] prev_x, prev_y, cur_x, cur_y, first_x, first_y;
  pgbx_flags_t                   qf;
  pgbx_flags_t                   f1, f2, f3;
  logic                          v1, v2, v3;
  logic                          en;
  logic                          hit_a, hit_b;
  logic                          hit_now;
  logic                          hit_seen;

  assign {qf, prev_x, prev_y, cur_x, cur_y, first_x, first_y} = q_data;

  assign en    = !result.valid || result.ready;
  assign q_pop = en;

  pgbx_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_a (
    .clk(clk), .en(en),
    .sx(prev_x), .sy(prev_y), .ex(cur_x), .ey(cur_y),
    .xl(box_x_lo), .xh(box_x_hi), .yl(box_y_lo), .yh(box_y_hi),
    .hit(hit_a)
  );

  pgbx_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_b (
    .clk(clk), .en(en),
    .sx(cur_x), .sy(cur_y), .ex(first_x), .ey(first_y),
    .xl(box_x_lo), .xh(box_x_hi), .yl(box_y_lo), .yh(box_y_hi),
    .hit(hit_b)
  );

  assign hit_now = (f3.edge_a && hit_a) || (f3.edge_b && hit_b);

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= qf;
      f2 <= f1;
      f3 <= f2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      hit_seen       <= 1'b0;
      result.valid   <= 1'b0;
      result.crosses <= 1'b0;
    end else if (en) begin
      v1           <= q_valid;
      v2           <= v1;
      v3           <= v2;
      result.valid <= v3 && f3.poly_end;
      if (v3) begin
        if (f3.poly_end) begin
          result.crosses <= hit_seen || hit_now;
          hit_seen       <= 1'b0;
        end else if (hit_now) begin
          hit_seen <= 1'b1;
        end
      end
    end
  end
endmodule

@@ rtl/polygon_edge_box_cross_test.sv @@
// ----------------------------------------------------------------------------
// polygon_edge_box_cross_test
// tells whether any edge of a streamed polygon touches a configured box
// ----------------------------------------------------------------------------
// a poly_last vertex's result passes the queue write at acceptance, the three
// test stages and the output register
// throughput: one vertex per cycle unless stalled, from pipelined edge units
// reset: synchronous rst clears ring state, queue, valid bits, config and result registers
module polygon_edge_box_cross_test
  import pgbx_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  localparam int DATA_W     = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB   = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int ADDR_W     = ADDR_LSB + REG_IDX_W
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // streams
  pgbx_vertex_if.sink       vertex,
  pgbx_result_if.source     result
);
  localparam int QW = 6 * COORD_WIDTH + FLAGS_W;

  logic signed [COORD_WIDTH-1:0] box_x_lo, box_x_hi, box_y_lo, box_y_hi;
  logic                          close_ring;
  logic [REG_IDX_W-1:0]          reg_idx;
  logic                          wr_en;

  logic          q_push, q_full, q_pop, q_valid;
  logic [QW-1:0] q_in, q_out;

  // register file, writes land in the access phase
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x_lo   <= '0;
      box_x_hi   <= '0;
      box_y_lo   <= '0;
      box_y_hi   <= '0;
      close_ring <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_IDX_W'(REG_BOX_X_LO): box_x_lo   <= pwdata[COORD_WIDTH-1:0];
        REG_IDX_W'(REG_BOX_X_HI): box_x_hi   <= pwdata[COORD_WIDTH-1:0];
        REG_IDX_W'(REG_BOX_Y_LO): box_y_lo   <= pwdata[COORD_WIDTH-1:0];
        REG_IDX_W'(REG_BOX_Y_HI): box_y_hi   <= pwdata[COORD_WIDTH-1:0];
        REG_IDX_W'(REG_CLOSE):    close_ring <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back, box bounds sign extended to the bus
  always_comb begin
    case (reg_idx)
      REG_IDX_W'(REG_BOX_X_LO): prdata = DATA_W'(box_x_lo);
      REG_IDX_W'(REG_BOX_X_HI): prdata = DATA_W'(box_x_hi);
      REG_IDX_W'(REG_BOX_Y_LO): prdata = DATA_W'(box_y_lo);
      REG_IDX_W'(REG_BOX_Y_HI): prdata = DATA_W'(box_y_hi);
      REG_IDX_W'(REG_CLOSE):    prdata = {{(DATA_W-1){1'b0}}, close_ring};
      default:                  prdata = '0;
    endcase
  end

  // front: ring bookkeeping, one job per vertex transaction
  pgbx_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .close_ring(close_ring), .vertex(vertex),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  // short job queue so each side can stall on its own
  pgbx_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
  );

  // back: edge test pipelines for both edges of a job and the result register
  pgbx_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk(clk), .rst(rst),
    .box_x_lo(box_x_lo), .box_x_hi(box_x_hi),
    .box_y_lo(box_y_lo), .box_y_hi(box_y_hi),
    .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop),
    .result(result)
  );
endmodule

@@ verif/polygon_edge_box_cross_test_test.sv @@
// ----------------------------------------------------------------------------
// polygon_edge_box_cross_test_test
// checks the polygon edge versus box test against an exact predictor
// ----------------------------------------------------------------------------
// polygons are streamed as vertex transactions under random idling on both
// channels; every poly_last vertex gets a predicted crosses bit that is
// compared with the next result transaction. the box and close_ring are
// reprogrammed between phases while the block is idle.
`timescale 1ns / 1ps

module polygon_edge_box_cross_test_test;
  import pgbx_pkg::*;

  localparam int CW = 32;
  localparam int AW = 5;
  localparam longint LIMIT = 1000000;

  // exact crossing predictor, keeps its own ring state and box
  class crossing_board;
    longint bxl, bxh, byl, byh;
    bit     close_en;
    longint first_x, first_y, last_x, last_y;
    bit     in_ring, hit;
    bit     want_q[$];
    int     errors;

    function void set_reg(int idx, logic [31:0] v);
      case (idx)
        REG_BOX_X_LO: bxl = longint'($signed(v));
        REG_BOX_X_HI: bxh = longint'($signed(v));
        REG_BOX_Y_LO: byl = longint'($signed(v));
        REG_BOX_Y_HI: byh = longint'($signed(v));
        REG_CLOSE:    close_en = v[0];
        default: ;
      endcase
    endfunction

    // one box side line: level lvl on the axis with start s0 and delta den
    function bit side(longint lvl, longint s0, longint den, longint o0,
                      longint num, longint slo, longint shi);
      logic signed [127:0] n, d, lhs;
      n = lvl - s0;
      d = den;
      if (d == 0) return 0;
      if (d < 0) begin
        d = -d;
        n = -n;
      end
      if (n < 0 || n > d) return 0;
      lhs = num * n;
      return ((slo - o0) * d <= lhs) && (lhs <= (shi - o0) * d);
    endfunction

    function bit meets(longint a1, longint a2, longint b1, longint b2);
      longint t;
      if (a2 < a1) begin t = a1; a1 = a2; a2 = t; end
      if (b2 < b1) begin t = b1; b1 = b2; b2 = t; end
      return ((a1 < b1) ? b1 : a1) <= ((a2 < b2) ? a2 : b2);
    endfunction

    function bit edge_touches(longint x0, longint y0, longint x1, longint y1);
      if (!meets(x0, x1, bxl, bxh) || !meets(y0, y1, byl, byh)) return 0;
      if (bxl <= x1 && x1 <= bxh && byl <= y1 && y1 <= byh) return 1;
      if (bxl <= x0 && x0 <= bxh && byl <= y0 && y0 <= byh) return 1;
      if (side(byl, y0, y1 - y0, x0, x1 - x0, bxl, bxh)) return 1;
      if (side(byh, y0, y1 - y0, x0, x1 - x0, bxl, bxh)) return 1;
      if (side(bxl, x0, x1 - x0, y0, y1 - y0, byl, byh)) return 1;
      if (side(bxh, x0, x1 - x0, y0, y1 - y0, byl, byh)) return 1;
      return 0;
    endfunction

    function void note_vertex(logic [CW-1:0] vx, logic [CW-1:0] vy, bit rl, bit pl);
      longint x, y;
      bit ring_end;
      x = longint'($signed(vx));
      y = longint'($signed(vy));
      ring_end = rl | pl;
      if (!in_ring) begin
        first_x = x;
        first_y = y;
      end else if (edge_touches(last_x, last_y, x, y)) hit = 1;
      if (ring_end && close_en && edge_touches(x, y, first_x, first_y)) hit = 1;
      last_x = x;
      last_y = y;
      in_ring = !ring_end;
      if (pl) begin
        want_q.push_back(hit);
        hit = 0;
      end
    endfunction

    function void check_result(bit got);
      bit want;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result crosses=%0d", got);
        return;
      end
      want = want_q.pop_front();
      if (want !== got) begin
        errors++;
        if (errors <= 10) $display("crosses mismatch: expected %0d actual %0d", want, got);
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  pgbx_vertex_if #(.COORD_WIDTH(CW)) vtx();
  pgbx_result_if res();

  polygon_edge_box_cross_test #(.COORD_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .vertex(vtx.sink), .result(res.source)
  );

  crossing_board board = new();
  longint cycles;
  int     hold_off;        // long receiver stall requested by the stimulus
  bit     calm;            // no random idling while set

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // accepted vertex transactions feed the predictor, results are checked
  always @(posedge clk) begin
    if (!rst && vtx.valid && vtx.ready)
      board.note_vertex(vtx.vertex_x, vtx.vertex_y, vtx.ring_last, vtx.poly_last);
    if (!rst && res.valid && res.ready) board.check_result(res.crosses);
  end

  // receiver: random stalls, plus a long hold-off counted here
  always @(negedge clk) begin
    if (rst) res.ready <= 0;
    else if (hold_off > 0) begin
      res.ready <= 0;
      hold_off <= hold_off - 1;
    end else res.ready <= calm || ($urandom_range(99) >= 17);
  end

  task automatic reg_write(int idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AW'(idx * 4); pwdata <= v;
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    board.set_reg(idx, v);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // one vertex transaction, with random gap before it
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, bit rl, bit pl);
    while (!calm && $urandom_range(99) < 17) begin
      vtx.valid <= 0;
      @(negedge clk);
    end
    vtx.valid <= 1;
    vtx.vertex_x <= x;
    vtx.vertex_y <= y;
    vtx.ring_last <= rl;
    vtx.poly_last <= pl;
    do @(posedge clk); while (!vtx.ready);
    @(negedge clk);
  endtask

  task automatic pause_line();
    vtx.valid <= 0;
  endtask

  // wait for every expected result, then let the pipeline drain
  task automatic drain();
    vtx.valid <= 0;
    while (board.want_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // coordinate: mostly near the box, sometimes anywhere or an extreme
  function automatic logic [31:0] coord(longint lo, longint hi);
    int r;
    r = $urandom_range(99);
    if (r < 8) return $urandom();
    if (r < 12) return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
    if (r < 20) return ($urandom_range(1)) ? 32'(lo) : 32'(hi);
    return 32'(lo + $signed($urandom_range(0, 32'(hi - lo + 40))) - 20);
  endfunction

  task automatic random_phase(int n, bit narrow);
    longint xl, xh, yl, yh, w;
    int left, verts, rings;
    xl = board.bxl; xh = board.bxh; yl = board.byl; yh = board.byh;
    if (xl > xh) begin w = xl; xl = xh; xh = w; end
    if (yl > yh) begin w = yl; yl = yh; yh = w; end
    if (narrow || xh - xl > 1000) xh = xl + 200;
    if (narrow || yh - yl > 1000) yh = yl + 200;
    left = n;
    while (left > 0) begin
      rings = $urandom_range(1, 3);
      for (int r = 0; r < rings; r++) begin
        verts = $urandom_range(1, 6);
        for (int v = 0; v < verts; v++) begin
          send_vertex(coord(xl, xh), coord(yl, yh), v == verts - 1,
                      (v == verts - 1) && (r == rings - 1));
          left--;
        end
      end
    end
    pause_line();
  endtask

  task automatic set_box(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
                         logic [31:0] yh, bit cl);
    reg_write(REG_BOX_X_LO, xl);
    reg_write(REG_BOX_X_HI, xh);
    reg_write(REG_BOX_Y_LO, yl);
    reg_write(REG_BOX_Y_HI, yh);
    reg_write(REG_CLOSE, {31'b0, cl});
  endtask

  initial begin
    rst = 1; cycles = 0; hold_off = 0; calm = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    vtx.valid = 0; vtx.vertex_x = 0; vtx.vertex_y = 0;
    vtx.ring_last = 0; vtx.poly_last = 0;
    res.ready = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: box [0,100]^2 with closing edges
    set_box(0, 100, 0, 100, 1);
    send_vertex(-50, 50, 0, 0);           // horizontal edge straight through
    send_vertex(150, 50, 0, 1);
    send_vertex(50, 50, 0, 1);            // single point inside, closing edge
    send_vertex(200, 200, 0, 1);          // single point outside
    send_vertex(-10, 120, 0, 0);          // diagonal ending on the top side
    send_vertex(10, 100, 0, 1);
    send_vertex(-10, 50, 1, 0);           // single-point ring outside
    send_vertex(-10, 60, 0, 0);           // second ring meets x = 0 above the box
    send_vertex(0, 200, 0, 1);
    send_vertex(32'h80000000, 32'h80000000, 0, 0);  // full-range diagonal
    send_vertex(32'h7fffffff, 32'h7fffffff, 0, 1);
    send_vertex(32'h7fffffff, 32'h80000000, 0, 0);
    send_vertex(32'h80000000, 32'h7fffffff, 0, 1);
    send_vertex(150, -20, 0, 0);          // closing edge alone crosses
    send_vertex(150, 120, 0, 0);
    send_vertex(-20, 120, 0, 1);
    drain();
    reg_write(REG_CLOSE, 0);
    send_vertex(150, -20, 0, 0);          // same polygon, closing edge skipped
    send_vertex(150, 120, 0, 0);
    send_vertex(-20, 120, 0, 1);
    drain();
    // inverted box: only the sorted overlap test can pass
    set_box(100, 0, 100, 0, 1);
    send_vertex(50, 50, 0, 1);
    send_vertex(-50, 50, 0, 0);
    send_vertex(150, 50, 0, 1);
    drain();

    // random phases over several box settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_box(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1);
        1: set_box(0, 0, 0, 0, 0);
        2: set_box(32'h7fffff00, 32'h7fffffff, 32'h80000000, 32'h80000100, 1);
        default: set_box($urandom_range(0, 400) - 200, $urandom_range(0, 400),
                         $urandom_range(0, 400) - 200, $urandom_range(0, 400),
                         1'($urandom_range(1)));
      endcase
      if (ph == 3) begin
        // long receiver stall while vertices keep coming
        hold_off = 300;
        calm = 1;
        random_phase(150, 0);
        calm = 0;
      end else if (ph == 4) begin
        calm = 1;
        random_phase(200, 0);
        calm = 0;
      end else random_phase(200, ph == 1);
      drain();                               // sender waits for every result
    end

    while (board.want_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (board.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ polygon_edge_box_cross_test.f @@
rtl/pgbx_pkg.sv
rtl/pgbx_if.sv
rtl/pgbx_queue.sv
rtl/pgbx_front.sv
rtl/pgbx_edge.sv
rtl/pgbx_back.sv
rtl/polygon_edge_box_cross_test.sv
verif/polygon_edge_box_cross_test_test.sv
